@@ design/gsst_pkg.sv @@
// Shared types, constants and helper functions of the Gini split search table.
package gsst_pkg;

  // Sizes of the node table and of the counters.
  localparam int NODE_COUNT = 1024;
  localparam int NODE_BITS  = $clog2(NODE_COUNT);
  localparam int CNT_BITS   = 16;
  localparam int FEAT_BITS  = 8;
  localparam int VAL_BITS   = 32;
  localparam int NUM_BITS   = 48;
  localparam int DEN_BITS   = 32;
  localparam int CROSS_BITS = NUM_BITS + DEN_BITS;
  localparam int MISS_BITS  = 16;

  // Word widths on the stream ports.
  localparam int KIND_BITS   = 3;
  localparam int S_DATA_BITS = 56;
  localparam int M_DATA_BITS = 96;

  // Item kinds.
  localparam logic [KIND_BITS-1:0] KIND_CLEAR = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_COUNT = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_START = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_VISIT = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_READ  = 3'd4;

  // Multiplier sequence: steps 0 to MUL_LAST.
  localparam int STEP_BITS = 4;
  localparam logic [STEP_BITS-1:0] MUL_LAST = 4'd9;

  // One node's record as kept in the table memory.
  typedef struct packed {
    logic [CNT_BITS-1:0]  node_total;
    logic [CNT_BITS-1:0]  node_true;
    logic [CNT_BITS-1:0]  left_total;
    logic [CNT_BITS-1:0]  left_true;
    logic [CNT_BITS-1:0]  right_true;
    logic [VAL_BITS-1:0]  last_value;
    logic [FEAT_BITS-1:0] pass_feature;
    logic                 scanning;
    logic                 best_found;
    logic [FEAT_BITS-1:0] best_feat;
    logic [VAL_BITS-1:0]  best_thresh;
    logic [MISS_BITS-1:0] best_miss;
    logic [NUM_BITS-1:0]  best_numer;
    logic [DEN_BITS-1:0]  best_denom;
  } node_rec_t;

  localparam int REC_BITS = $bits(node_rec_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 clr;
    logic [NODE_BITS-1:0] clr_addr;
    logic                 accept;
    logic                 load;
    logic                 mul;
    logic [STEP_BITS-1:0] step;
    logic                 commit;
  } gsst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic weigh;
    logic out_stall;
  } gsst_sts_t;

  // Counter increment that holds at the maximum.
  function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] c);
    sat_inc = (c == {CNT_BITS{1'b1}}) ? c : c + 1'b1;
  endfunction

  function automatic logic [CNT_BITS-1:0] min_cnt(input logic [CNT_BITS-1:0] a,
                                                  input logic [CNT_BITS-1:0] b);
    min_cnt = (a < b) ? a : b;
  endfunction

endpackage

@@ design/gsst_ram.sv @@
// Generic single-port RAM with a registered read.
module gsst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read first port: a read during a write returns the old contents.
  // Read data shows the following cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/gsst_ctrl.sv @@
// Controller state machine of the Gini split search table.
module gsst_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  gsst_pkg::gsst_sts_t sts_i,
  output gsst_pkg::gsst_cmd_t cmd_o
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_LOAD = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_UPD  = 3'd5;

  logic [2:0]                     state_q, state_d;
  logic [gsst_pkg::NODE_BITS-1:0] clr_q, clr_d;
  logic [gsst_pkg::STEP_BITS-1:0] step_q, step_d;

  // Next state logic.
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    step_d  = step_q;
    case (state_q)
      ST_CLR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == {gsst_pkg::NODE_BITS{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid_i) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        step_d  = '0;
        state_d = sts_i.weigh ? ST_MUL : ST_UPD;
      end
      ST_MUL: begin
        step_d = step_q + 1'b1;
        if (step_q == gsst_pkg::MUL_LAST) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (!sts_i.out_stall) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      clr_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      step_q  <= step_d;
    end
  end

  // Command word to the datapath.
  always_comb begin
    cmd_o.clr      = (state_q == ST_CLR);
    cmd_o.clr_addr = clr_q;
    cmd_o.accept   = (state_q == ST_IDLE);
    cmd_o.load     = (state_q == ST_LOAD);
    cmd_o.mul      = (state_q == ST_MUL);
    cmd_o.step     = step_q;
    cmd_o.commit   = (state_q == ST_UPD) && !sts_i.out_stall;
  end

endmodule

@@ design/gsst_dp.sv @@
// Datapath: item register, node record, shared multiplier and result register.
module gsst_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gsst_pkg::gsst_cmd_t                 cmd_i,
  output gsst_pkg::gsst_sts_t                 sts_o,
  input  logic                                s_tvalid_i,
  input  logic [gsst_pkg::S_DATA_BITS-1:0]    s_tdata_i,
  input  logic [gsst_pkg::KIND_BITS-1:0]      s_tuser_i,
  input  logic                                m_tready_i,
  output logic                                m_tvalid_o,
  output logic [gsst_pkg::M_DATA_BITS-1:0]    m_tdata_o
);

  localparam int CB = gsst_pkg::CNT_BITS;

  // Item fields.
  logic [gsst_pkg::KIND_BITS-1:0] kind_q;
  logic [gsst_pkg::NODE_BITS-1:0] node_q;
  logic [gsst_pkg::FEAT_BITS-1:0] feat_q;
  logic [gsst_pkg::VAL_BITS-1:0]  value_q;
  logic                           label_q;
  logic                           scan_q;

  gsst_pkg::node_rec_t rec_q, rec_new, ram_rdata, ram_wdata;
  logic [gsst_pkg::NODE_BITS-1:0] ram_addr;
  logic                           ram_we;

  logic [63:0]                     prod_q;
  logic [31:0]                     mul_a, mul_b;
  logic [gsst_pkg::NUM_BITS-1:0]   num_q;
  logic [gsst_pkg::DEN_BITS-1:0]   den_q;
  logic [gsst_pkg::CROSS_BITS-1:0] x_q, y_q;

  logic [CB-1:0] nl, tl, nr, tr, fl, fr;
  logic [CB:0]   miss_sum;
  logic          weigh, weigh_rd, better;

  logic                              m_valid_q;
  logic [gsst_pkg::M_DATA_BITS-1:0]  m_data_q;

  // Capture the word on acceptance.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && s_tvalid_i) begin
      kind_q  <= s_tuser_i;
      node_q  <= s_tdata_i[9:0];
      feat_q  <= s_tdata_i[17:10];
      value_q <= s_tdata_i[49:18];
      label_q <= s_tdata_i[50];
      scan_q  <= s_tdata_i[51];
    end
    if (cmd_i.load) begin
      rec_q <= ram_rdata;
    end
  end

  // Node table, cleared by a sweep after reset.
  assign ram_addr  = cmd_i.clr ? cmd_i.clr_addr : node_q;
  assign ram_we    = cmd_i.clr || cmd_i.commit;
  assign ram_wdata = cmd_i.clr ? '0 : rec_new;

  gsst_ram #(
    .WIDTH(gsst_pkg::REC_BITS),
    .DEPTH(gsst_pkg::NODE_COUNT)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // Left and right counts of the candidate split.
  assign nl = rec_q.left_total;
  assign tl = rec_q.left_true;
  assign nr = rec_q.node_total - rec_q.left_total;
  assign tr = rec_q.right_true;
  assign fl = nl - tl;
  assign fr = (tr > nr) ? '0 : nr - tr;

  assign weigh = (kind_q == gsst_pkg::KIND_VISIT) && rec_q.scanning &&
                 (value_q != rec_q.last_value) && (rec_q.left_total != '0) &&
                 (rec_q.left_total < rec_q.node_total);

  // Same decision taken on the record as it leaves the table, for the controller.
  assign weigh_rd = (kind_q == gsst_pkg::KIND_VISIT) && ram_rdata.scanning &&
                    (value_q != ram_rdata.last_value) && (ram_rdata.left_total != '0) &&
                    (ram_rdata.left_total < ram_rdata.node_total);

  // Multiplier operands per step; steps 1 and 3 use the previous product.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.step)
      4'd0: begin mul_a = 32'(tl);               mul_b = 32'(fl); end
      4'd1: begin mul_a = prod_q[31:0];          mul_b = 32'(nr); end
      4'd2: begin mul_a = 32'(tr);               mul_b = 32'(fr); end
      4'd3: begin mul_a = prod_q[31:0];          mul_b = 32'(nl); end
      4'd4: begin mul_a = 32'(nl);               mul_b = 32'(nr); end
      4'd5: begin mul_a = num_q[31:0];           mul_b = rec_q.best_denom; end
      4'd6: begin mul_a = 32'(num_q[47:32]);     mul_b = rec_q.best_denom; end
      4'd7: begin mul_a = rec_q.best_numer[31:0]; mul_b = den_q; end
      4'd8: begin mul_a = 32'(rec_q.best_numer[47:32]); mul_b = den_q; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Product register and accumulation of the numerator, denominator and cross products.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= mul_a * mul_b;
      case (cmd_i.step)
        4'd2: num_q <= prod_q[47:0];
        4'd4: num_q <= num_q + prod_q[47:0];
        4'd5: den_q <= prod_q[31:0];
        4'd6: x_q   <= gsst_pkg::CROSS_BITS'(prod_q);
        4'd7: x_q   <= x_q + {prod_q[47:0], 32'd0};
        4'd8: y_q   <= gsst_pkg::CROSS_BITS'(prod_q);
        4'd9: y_q   <= y_q + {prod_q[47:0], 32'd0};
        default: ;
      endcase
    end
  end

  // A new split wins when no best is stored yet, or else only when strictly lower.
  assign better   = !rec_q.best_found || (x_q < y_q);
  assign miss_sum = {1'b0, gsst_pkg::min_cnt(tl, fl)} + {1'b0, gsst_pkg::min_cnt(tr, fr)};

  // Updated record for each kind.
  always_comb begin
    rec_new = rec_q;
    case (kind_q)
      gsst_pkg::KIND_CLEAR: begin
        rec_new.node_total  = '0;
        rec_new.node_true   = '0;
        rec_new.best_found  = 1'b0;
        rec_new.best_feat   = '0;
        rec_new.best_thresh = '0;
        rec_new.best_miss   = '0;
        rec_new.best_numer  = '0;
        rec_new.best_denom  = '0;
      end
      gsst_pkg::KIND_COUNT: begin
        rec_new.node_total = gsst_pkg::sat_inc(rec_q.node_total);
        if (label_q) begin
          rec_new.node_true = gsst_pkg::sat_inc(rec_q.node_true);
        end
      end
      gsst_pkg::KIND_START: begin
        rec_new.last_value   = '0;
        rec_new.left_total   = '0;
        rec_new.left_true    = '0;
        rec_new.right_true   = rec_q.node_true;
        rec_new.pass_feature = feat_q;
        rec_new.scanning     = scan_q;
      end
      gsst_pkg::KIND_VISIT: begin
        if (rec_q.scanning) begin
          if (weigh && better) begin
            rec_new.best_found  = 1'b1;
            rec_new.best_feat   = rec_q.pass_feature;
            rec_new.best_thresh = value_q;
            rec_new.best_miss   = miss_sum[CB] ? {CB{1'b1}} : miss_sum[CB-1:0];
            rec_new.best_numer  = num_q;
            rec_new.best_denom  = den_q;
          end
          if (label_q) begin
            rec_new.left_true = gsst_pkg::sat_inc(rec_q.left_true);
            if (rec_q.right_true != '0) begin
              rec_new.right_true = rec_q.right_true - 1'b1;
            end
          end
          rec_new.left_total = gsst_pkg::sat_inc(rec_q.left_total);
          rec_new.last_value = value_q;
        end
      end
      default: ;
    endcase
  end

  // Result register, free to take the next word while a result waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.commit && kind_q == gsst_pkg::KIND_READ) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && kind_q == gsst_pkg::KIND_READ) begin
      m_data_q <= {6'd0,
                   ({1'b0, rec_q.node_total} < {rec_q.node_true, 1'b0}),
                   rec_q.node_true, rec_q.node_total, rec_q.best_miss,
                   rec_q.best_thresh, rec_q.best_feat, rec_q.best_found};
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

  assign sts_o.weigh     = weigh_rd;
  assign sts_o.out_stall = (kind_q == gsst_pkg::KIND_READ) && m_valid_q && !m_tready_i;

endmodule

@@ design/gini_split_search_table.sv @@
// Top level of the Gini split search table.
// The block handles one word at a time: a read of the node record, an update and a
// write back; a visit that weighs a split also runs the ten steps of the shared
// 32 x 32 multiplier that forms the Gini fraction and its exact cross compare
// against the stored best. After reset the block sweeps the 1024-entry node table
// to zero and takes no word until the sweep ends. A read result sits in an output
// register, so the next word is taken while it waits; a further read word holds in
// its last cycle until the waiting result is taken.
module gini_split_search_table (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // node[9:0], feature[17:10], value[49:18], label[50], scan[51], zeros above
  input  logic [gsst_pkg::S_DATA_BITS-1:0] s_axis_tdata_i,
  // kind[2:0]
  input  logic [gsst_pkg::KIND_BITS-1:0]   s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // found[0], best_feature[8:1], best_value[40:9], mislabeled[56:41],
  // total_count[72:57], true_count[88:73], majority[89], zeros above
  output logic [gsst_pkg::M_DATA_BITS-1:0] m_axis_tdata_o
);

  gsst_pkg::gsst_cmd_t cmd;
  gsst_pkg::gsst_sts_t sts;

  gsst_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  gsst_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .s_tvalid_i(s_axis_tvalid_i),
    .s_tdata_i (s_axis_tdata_i),
    .s_tuser_i (s_axis_tuser_i),
    .m_tready_i(m_axis_tready_i),
    .m_tvalid_o(m_axis_tvalid_o),
    .m_tdata_o (m_axis_tdata_o)
  );

  assign s_axis_tready_o = cmd.accept;

  // No word is taken while the table is being swept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr |-> !s_axis_tready_o)
    else $error("word accepted during table sweep");

  // A table write never coincides with taking a new word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.clr || cmd.commit) |-> !s_axis_tready_o)
    else $error("table write overlaps acceptance");

  // A result only appears after a read word was committed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(cmd.commit))
    else $error("result without a committed read");

endmodule
